[rtl/ectc_pkg.sv]
// ----------------------------------------------------------------------------
// ectc_pkg
// Shared types and constants for the epoch nanosecond to calendar converter.
// ----------------------------------------------------------------------------
package ectc_pkg;

    localparam int IN_W      = 64;
    localparam int OUT_W     = 88;
    localparam int NUM_W     = 32;
    localparam int DIVISOR_W = 21;
    localparam int RECIP_W   = 27;
    localparam int DIGIT_W   = 11;
    localparam int NS_LOW_W  = 9;
    localparam int SECS_W    = 35;
    localparam int DAYS32_W  = 16;

    // divisor and floor(2^32 / divisor) for each constant division
    // nanoseconds are split as 2^9 x 5^9, seconds per day as 2^7 x 675
    localparam logic [DIVISOR_W-1:0] NS_DIGIT_D = 21'd1953125;
    localparam logic [RECIP_W-1:0]   NS_DIGIT_M = 27'd2199;
    localparam logic [DIVISOR_W-1:0] DAY_HI_D   = 21'd675;
    localparam logic [RECIP_W-1:0]   DAY_HI_M   = 27'd6362914;
    localparam logic [DIVISOR_W-1:0] HOUR_D     = 21'd3600;
    localparam logic [RECIP_W-1:0]   HOUR_M     = 27'd1193046;
    localparam logic [DIVISOR_W-1:0] MIN_D      = 21'd60;
    localparam logic [RECIP_W-1:0]   MIN_M      = 27'd71582788;
    localparam logic [DIVISOR_W-1:0] DATE_D     = 21'd86400;
    localparam logic [RECIP_W-1:0]   DATE_M     = 27'd49710;

    localparam logic [2:0] NS_LAST_DIGIT = 3'd4;

    localparam logic [11:0] FIRST_YEAR     = 12'd1970;
    localparam logic [1:0]  FIRST_YEAR_M4  = 2'd2;
    localparam logic [6:0]  FIRST_YEAR_M100 = 7'd70;
    localparam logic [8:0]  FIRST_YEAR_M400 = 9'd370;
    localparam logic [8:0]  DAYS_LEAP_YEAR = 9'd366;
    localparam logic [8:0]  DAYS_YEAR      = 9'd365;
    localparam logic [4:0]  DAYS_FEB_LEAP  = 5'd29;
    localparam logic [3:0]  MONTH_FEB      = 4'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GO,
        ST_WAIT,
        ST_YEAR,
        ST_MONTH,
        ST_OUT
    } ectc_state_t;

    typedef enum logic [2:0] {
        OP_NS,
        OP_DAYS,
        OP_HOUR,
        OP_MIN,
        OP_DATE
    } div_op_t;

    typedef struct packed {
        logic    load_in;
        logic    div_start;
        logic    div_cap;
        div_op_t op;
        logic    year_step;
        logic    month_step;
        logic    load_out;
    } ectc_cmd_t;

    typedef struct packed {
        logic div_done;
        logic ns_last;
        logic year_done;
        logic month_done;
    } ectc_sts_t;

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        unique case (month)
            4'd0:      len = 5'd31;
            MONTH_FEB: len = leap ? DAYS_FEB_LEAP : 5'd28;
            4'd2:      len = 5'd31;
            4'd3:      len = 5'd30;
            4'd4:      len = 5'd31;
            4'd5:      len = 5'd30;
            4'd6:      len = 5'd31;
            4'd7:      len = 5'd31;
            4'd8:      len = 5'd30;
            4'd9:      len = 5'd31;
            4'd10:     len = 5'd30;
            4'd11:     len = 5'd31;
            default:   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

[rtl/ectc_div.sv]
// ----------------------------------------------------------------------------
// ectc_div
// Constant divider for dividends up to 32 bits by reciprocal multiplication.
// The high half of dividend x floor(2^32 / divisor) is low by at most one, so
// a multiply back and one compare and subtract settle it. done pulses after
// start has passed through the estimate, back, fix and done registers.
// ----------------------------------------------------------------------------
module ectc_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [ectc_pkg::NUM_W-1:0]       dividend,
    input  logic [ectc_pkg::DIVISOR_W-1:0]   divisor,
    input  logic [ectc_pkg::RECIP_W-1:0]     recip,
    output logic                             done,
    output logic [ectc_pkg::NUM_W-1:0]       quotient,
    output logic [ectc_pkg::DIVISOR_W-1:0]   remainder
);
    import ectc_pkg::*;

    logic                     est_reg;
    logic                     back_reg;
    logic                     fix_reg;
    logic                     done_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [DIVISOR_W-1:0]     div_reg;
    logic [RECIP_W-1:0]       recip_reg;
    logic [NUM_W-1:0]         quo_reg;
    logic [NUM_W-1:0]         rem_reg;
    logic [NUM_W+RECIP_W-1:0] prod;
    logic [NUM_W-1:0]         div_wide;
    logic [NUM_W-1:0]         quo_back;
    logic                     fits;

    always_comb begin
        div_wide = {{(NUM_W-DIVISOR_W){1'b0}}, div_reg};
        prod     = {{RECIP_W{1'b0}}, num_reg} * {{NUM_W{1'b0}}, recip_reg};
        // never exceeds the dividend, so 32 bits hold it
        quo_back = quo_reg * div_wide;
        fits     = (rem_reg >= div_wide);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            est_reg  <= 1'b0;
            back_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            est_reg  <= start;
            back_reg <= est_reg;
            fix_reg  <= back_reg;
            done_reg <= fix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg   <= dividend;
            div_reg   <= divisor;
            recip_reg <= recip;
        end else if (est_reg) begin
            quo_reg <= {{(NUM_W-RECIP_W){1'b0}}, prod[NUM_W+RECIP_W-1:NUM_W]};
        end else if (back_reg) begin
            rem_reg <= num_reg - quo_back;
        end else if (fix_reg && fits) begin
            quo_reg <= quo_reg + 32'd1;
            rem_reg <= rem_reg - div_wide;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[DIVISOR_W-1:0];

endmodule

[rtl/ectc_dp.sv]
// ----------------------------------------------------------------------------
// ectc_dp
// Datapath: shared divider, time-of-day fields, year and month walk and the
// output register.
// ----------------------------------------------------------------------------
module ectc_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ectc_pkg::ectc_cmd_t         cmd,
    output ectc_pkg::ectc_sts_t         sts,
    input  logic [ectc_pkg::IN_W-1:0]   ns_in,
    output logic [ectc_pkg::OUT_W-1:0]  out_data
);
    import ectc_pkg::*;

    logic [NUM_W-1:0]     div_dividend;
    logic [DIVISOR_W-1:0] div_divisor;
    logic [RECIP_W-1:0]   div_recip;
    logic                 div_done;
    logic [NUM_W-1:0]     div_quo;
    logic [DIVISOR_W-1:0] div_rem;

    logic [IN_W-1:0]      ns_reg;
    logic [NS_LOW_W-1:0]  lo_reg;
    logic [2:0]           dig_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [SECS_W-1:0]    secs_reg;
    logic [16:0]          tod_reg;
    logic [11:0]          mrem_reg;
    logic [5:0]           sec_reg;
    logic [5:0]           min_reg;
    logic [4:0]           hour_reg;
    logic [17:0]          dcount_reg;
    logic [DAYS32_W-1:0]  days_reg;
    logic [11:0]          year_reg;
    logic [1:0]           m4_reg;
    logic [6:0]           m100_reg;
    logic [8:0]           m400_reg;
    logic [3:0]           month_reg;
    logic [OUT_W-1:0]     out_reg;

    logic [29:0]          nsec;
    logic                 leap;
    logic [8:0]           ylen;
    logic [4:0]           mlen;
    logic                 year_done;
    logic                 month_done;
    logic [3:0]           month_out;
    logic [4:0]           dom_out;

    ectc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .recip     (div_recip),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // nanoseconds over 2^9 go through 5^9 one 11-bit digit at a time, top first
    always_comb begin
        unique case (cmd.op)
            OP_NS: begin
                div_dividend = {rem_reg, ns_reg[IN_W-1 -: DIGIT_W]};
                div_divisor  = NS_DIGIT_D;
                div_recip    = NS_DIGIT_M;
            end
            OP_DAYS: begin
                div_dividend = {4'd0, secs_reg[SECS_W-1:7]};
                div_divisor  = DAY_HI_D;
                div_recip    = DAY_HI_M;
            end
            OP_HOUR: begin
                div_dividend = {15'd0, tod_reg};
                div_divisor  = HOUR_D;
                div_recip    = HOUR_M;
            end
            OP_MIN: begin
                div_dividend = {20'd0, mrem_reg};
                div_divisor  = MIN_D;
                div_recip    = MIN_M;
            end
            OP_DATE: begin
                div_dividend = secs_reg[31:0];
                div_divisor  = DATE_D;
                div_recip    = DATE_M;
            end
            default: begin
                div_dividend = {rem_reg, ns_reg[IN_W-1 -: DIGIT_W]};
                div_divisor  = NS_DIGIT_D;
                div_recip    = NS_DIGIT_M;
            end
        endcase
    end

    always_comb begin
        nsec       = {rem_reg, lo_reg};
        leap       = (m4_reg == 2'd0) && ((m100_reg != 7'd0) || (m400_reg == 9'd0));
        ylen       = leap ? DAYS_LEAP_YEAR : DAYS_YEAR;
        mlen       = month_len(month_reg, leap);
        year_done  = (days_reg < {7'd0, ylen});
        month_done = (days_reg < {11'd0, mlen});
        month_out  = month_reg + 4'd1;
        dom_out    = days_reg[4:0] + 5'd1;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            ns_reg   <= ns_in;
            lo_reg   <= ns_in[NS_LOW_W-1:0];
            dig_reg  <= '0;
            rem_reg  <= '0;
            secs_reg <= '0;
        end else if (cmd.div_cap) begin
            unique case (cmd.op)
                OP_NS: begin
                    rem_reg  <= div_rem;
                    secs_reg <= {secs_reg[SECS_W-DIGIT_W-1:0], div_quo[DIGIT_W-1:0]};
                    ns_reg   <= {ns_reg[IN_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    dig_reg  <= dig_reg + 3'd1;
                end
                // remainder of the day rebuilt from the 675 remainder and low bits
                OP_DAYS: begin
                    dcount_reg <= div_quo[17:0];
                    tod_reg    <= {div_rem[9:0], secs_reg[6:0]};
                end
                OP_HOUR: begin
                    hour_reg <= div_quo[4:0];
                    mrem_reg <= div_rem[11:0];
                end
                OP_MIN: begin
                    min_reg <= div_quo[5:0];
                    sec_reg <= div_rem[5:0];
                end
                OP_DATE: begin
                    days_reg  <= div_quo[DAYS32_W-1:0];
                    year_reg  <= FIRST_YEAR;
                    m4_reg    <= FIRST_YEAR_M4;
                    m100_reg  <= FIRST_YEAR_M100;
                    m400_reg  <= FIRST_YEAR_M400;
                    month_reg <= '0;
                end
                default: dig_reg <= dig_reg;
            endcase
        end else if (cmd.year_step && !year_done) begin
            days_reg <= days_reg - {7'd0, ylen};
            year_reg <= year_reg + 12'd1;
            m4_reg   <= m4_reg + 2'd1;
            m100_reg <= (m100_reg == 7'd99) ? 7'd0 : m100_reg + 7'd1;
            m400_reg <= (m400_reg == 9'd399) ? 9'd0 : m400_reg + 9'd1;
        end else if (cmd.month_step && !month_done) begin
            days_reg  <= days_reg - {11'd0, mlen};
            month_reg <= month_reg + 4'd1;
        end
    end

    // fields from the highest bit down
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg <= {2'b00, dom_out, month_out, year_reg, dcount_reg,
                        hour_reg, min_reg, sec_reg, nsec};
        end
    end

    assign sts.div_done   = div_done;
    assign sts.ns_last    = (dig_reg == NS_LAST_DIGIT);
    assign sts.year_done  = year_done;
    assign sts.month_done = month_done;
    assign out_data       = out_reg;

endmodule

[rtl/ectc_ctrl.sv]
// ----------------------------------------------------------------------------
// ectc_ctrl
// Controller: sequences the divisions, the year and month walk and the
// output handshake.
// ----------------------------------------------------------------------------
module ectc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  ectc_pkg::ectc_sts_t  sts,
    output ectc_pkg::ectc_cmd_t  cmd
);
    import ectc_pkg::*;

    ectc_state_t state_reg, state_next;
    div_op_t     op_reg, op_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_NS;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        cmd            = '0;
        cmd.op         = op_reg;
        s_tready       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    op_next     = OP_NS;
                    state_next  = ST_GO;
                end
            end
            ST_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_WAIT;
            end
            ST_WAIT: begin
                if (sts.div_done) begin
                    cmd.div_cap = 1'b1;
                    state_next  = ST_GO;
                    unique case (op_reg)
                        OP_NS: begin
                            if (sts.ns_last) begin
                                op_next = OP_DAYS;
                            end
                        end
                        OP_DAYS: op_next = OP_HOUR;
                        OP_HOUR: op_next = OP_MIN;
                        OP_MIN:  op_next = OP_DATE;
                        OP_DATE: state_next = ST_YEAR;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_YEAR: begin
                cmd.year_step = 1'b1;
                if (sts.year_done) begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH: begin
                cmd.month_step = 1'b1;
                if (sts.month_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // output register frees up when empty or being drained
                if (!out_valid_reg || m_tready) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

[rtl/epoch_ns_to_calendar.sv]
// ----------------------------------------------------------------------------
// epoch_ns_to_calendar
// Converts nanoseconds since 1970-01-01 UTC into time of day, day count and
// Gregorian date.
//
//   channel   dir  bits  contents
//   s_*       in   64    nanoseconds
//   m_*       out  88    nanosecond_part, second, minute, hour, day_count,
//                        year, month, day_of_month
//
// One item at a time; nine reciprocal divisions (five digits for the seconds,
// then day, hour, minute and the 32-bit date days), then a walk of one year
// per step from 1970 and of one month per step, then a load of the output
// register; no new item is accepted before that load. A result not yet taken
// stalls the next load.
// Reset is synchronous, active low, and clears the controller and divider.
// ----------------------------------------------------------------------------
module epoch_ns_to_calendar (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // nanoseconds [63:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // nanosecond_part [29:0], second [35:30], minute [41:36], hour [46:42],
    // day_count [64:47], year [76:65], month [80:77], day_of_month [85:81]
    output logic [87:0] m_tdata
);
    import ectc_pkg::*;

    ectc_cmd_t cmd;
    ectc_sts_t sts;

    ectc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ectc_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .ns_in    (s_tdata),
        .out_data (m_tdata)
    );

`ifndef SYNTHESIS
    // a division never completes the cycle after it starts
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> !sts.div_done)
        else $error("divider finished right after start");

    // every completed division is captured by the waiting state
    assert property (@(posedge aclk) disable iff (!aresetn)
        sts.div_done |-> cmd.div_cap)
        else $error("division result dropped");

    // an accepted transfer closes the input until its result is loaded
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input reopened during conversion");

    // loading the output register always presents a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_tvalid)
        else $error("loaded result not presented");
`endif

endmodule
